// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared constants, status codes, mode codes and field widths.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int ARENA_MAX_BYTES = 65536;
    localparam int FREE_ENTRIES    = 64;
    localparam int LIVE_ENTRIES    = 64;
    localparam int HEADER_BYTES    = 16;

    localparam int LEN_W   = 17;
    localparam int OFS_W   = 16;
    localparam int ADJ_W   = 13;
    localparam int ALIGN_MAX = 12;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

// ===== design/ffa_live_table.sv =====
// ----------------------------------------------------------------------------
// Live-allocation table
// Grant records (offset, block length, adjustment) in one synchronous memory
// with per-entry valid bits. The controller scans it entry by entry for a
// free slot or a matching offset.
// ----------------------------------------------------------------------------
module ffa_live_table #(
    parameter int LIVE_ENTRIES = ffa_pkg::LIVE_ENTRIES,
    parameter int IDX_W        = $clog2(LIVE_ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic [IDX_W-1:0]         i_rd_idx,
    output logic                     o_rd_valid,
    output logic [ffa_pkg::OFS_W-1:0] o_rd_ofs,
    output logic [ffa_pkg::LEN_W-1:0] o_rd_len,
    output logic [ffa_pkg::ADJ_W-1:0] o_rd_adj,
    input  logic                     i_set,
    input  logic                     i_drop,
    input  logic [IDX_W-1:0]         i_wr_idx,
    input  logic [ffa_pkg::OFS_W-1:0] i_wr_ofs,
    input  logic [ffa_pkg::LEN_W-1:0] i_wr_len,
    input  logic [ffa_pkg::ADJ_W-1:0] i_wr_adj
);
    localparam int REC_W = ffa_pkg::OFS_W + ffa_pkg::LEN_W + ffa_pkg::ADJ_W;

    logic [REC_W-1:0]        mem [LIVE_ENTRIES];
    logic [REC_W-1:0]        r_rd;
    logic [LIVE_ENTRIES-1:0] r_valid;
    logic                    r_rd_valid;

    // Record memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_set) begin
            mem[i_wr_idx] <= {i_wr_ofs, i_wr_len, i_wr_adj};
        end
        r_rd <= mem[i_rd_idx];
    end

    // Valid bits, cleared at reset and on restart.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_set) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_drop) begin
                r_valid[i_wr_idx] <= 1'b0;
            end
            r_rd_valid <= r_valid[i_rd_idx];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign {o_rd_ofs, o_rd_len, o_rd_adj} = r_rd;
endmodule

// ===== design/ffa_seg_table.sv =====
// ----------------------------------------------------------------------------
// Free-segment table
// Address-sorted (start, length) pairs in one synchronous memory, one read
// and one write port, read data registered.
// ----------------------------------------------------------------------------
module ffa_seg_table #(
    parameter int FREE_ENTRIES = ffa_pkg::FREE_ENTRIES,
    parameter int IDX_W        = $clog2(FREE_ENTRIES)
) (
    input  logic                      i_clk,
    input  logic [IDX_W-1:0]          i_rd_idx,
    output logic [ffa_pkg::OFS_W:0]   o_rd_start,
    output logic [ffa_pkg::LEN_W-1:0] o_rd_len,
    input  logic                      i_we,
    input  logic [IDX_W-1:0]          i_wr_idx,
    input  logic [ffa_pkg::OFS_W:0]   i_wr_start,
    input  logic [ffa_pkg::LEN_W-1:0] i_wr_len
);
    localparam int REC_W = ffa_pkg::OFS_W + 1 + ffa_pkg::LEN_W;

    logic [REC_W-1:0] mem [FREE_ENTRIES];
    logic [REC_W-1:0] r_rd;

    // Write and registered read; the controller never reads an entry in the
    // cycle after writing it without first waiting.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_idx] <= {i_wr_start, i_wr_len};
        end
        r_rd <= mem[i_rd_idx];
    end

    assign {o_rd_start, o_rd_len} = r_rd;
endmodule

// ===== design/first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// First-fit free-list allocator
// Allocates and frees blocks of one arena from an address-sorted free list.
// ----------------------------------------------------------------------------
// Usage: pulse i_start with the item fields while o_busy is low. The item is
// taken at that edge and o_busy rises. One result follows on o_granted_offset,
// o_freed_bytes and o_status, marked by o_done for exactly one cycle; the
// receiver cannot stall it. o_busy falls with o_done.
// An item's run time grows with the free segments and live entries it scans,
// plus the segments shifted on insert or removal. The segment memory (one read
// port, one write port) and the live memory are walked one entry at a time:
// each entry is read, then used from the registered read data.
// Reset, and any write of arena_bytes (offset 0 of the APB port), restart the
// arena as one free segment and clear the live table; the first segment is
// rewritten by one write, so there is no clearing pass. o_busy stays high
// while segment zero is rewritten.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_unit #(
    parameter int FREE_ENTRIES    = ffa_pkg::FREE_ENTRIES,
    parameter int LIVE_ENTRIES    = ffa_pkg::LIVE_ENTRIES,
    parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [16:0] i_req_size,
    input  logic [3:0]  i_align_log2,
    input  logic [15:0] i_release_offset,
    output logic        o_done,
    output logic [15:0] o_granted_offset,
    output logic [16:0] o_freed_bytes,
    output logic [1:0]  o_status
);
    localparam int FI_W = $clog2(FREE_ENTRIES);
    localparam int LI_W = $clog2(LIVE_ENTRIES);
    localparam int FC_W = $clog2(FREE_ENTRIES + 1);
    localparam int LC_W = $clog2(LIVE_ENTRIES + 1);
    localparam int SW   = ffa_pkg::OFS_W + 1;     // 17-bit start/end
    localparam int LW   = ffa_pkg::LEN_W;
    localparam int AW   = ffa_pkg::ADJ_W;

    // State codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRD    = 4'd1;  // segment read issued
    localparam logic [3:0] S_SCHK   = 4'd2;  // alloc: check segment
    localparam logic [3:0] S_LRD    = 4'd3;  // live read issued
    localparam logic [3:0] S_LCHK   = 4'd4;  // live check
    localparam logic [3:0] S_FCHK   = 4'd5;  // free: find position
    localparam logic [3:0] S_SHRD   = 4'd6;  // shift read issued
    localparam logic [3:0] S_SHWR   = 4'd7;  // shift write
    localparam logic [3:0] S_NRD    = 4'd8;  // free: next segment read
    localparam logic [3:0] S_NCHK   = 4'd9;  // free: decide merge
    localparam logic [3:0] S_DONE   = 4'd10;

    // Follow-up after a live scan or a shift.
    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;

    logic [3:0]  r_state, n_state;
    logic [16:0] r_arena;
    logic [FC_W-1:0] r_cnt, n_cnt;
    logic        r_mode;
    logic [16:0] r_size;
    logic [3:0]  r_alog;
    logic [15:0] r_rel;
    logic [FC_W-1:0] r_i, n_i;          // segment index
    logic [LC_W-1:0] r_l, n_l;          // live index
    logic [LI_W-1:0] r_slot, n_slot;
    logic [SW-1:0]   r_bstart, n_bstart;
    logic [LW-1:0]   r_blen, n_blen;
    logic [AW-1:0]   r_adj, n_adj;
    logic [SW-1:0]   r_pend, n_pend;    // previous segment end
    logic            r_hasp, n_hasp;    // previous segment exists
    logic [LW-1:0]   r_plen, n_plen;
    logic [SW-1:0]   r_aligned, n_aligned;
    logic [FC_W-1:0] r_k, n_k;          // shift index
    logic            r_up, n_up;        // shift up (insert) or down (remove)
    logic [1:0]      r_kind, n_kind;
    logic            r_done, n_done;
    logic [15:0]     r_gofs, n_gofs;
    logic [16:0]     r_fb, n_fb;
    logic [1:0]      r_st, n_st;

    // Memory ports.
    logic [FI_W-1:0] seg_ri, seg_wi;
    logic            seg_we;
    logic [SW-1:0]   seg_rs, seg_ws;
    logic [LW-1:0]   seg_rl, seg_wl;
    logic [LI_W-1:0] live_ri, live_wi;
    logic            live_rv, live_set, live_drop;
    logic [15:0]     live_ro, live_wo;
    logic [LW-1:0]   live_rlen, live_wlen;
    logic [AW-1:0]   live_radj, live_wadj;

    // Segment write port after the restart path.
    logic            r_init;
    logic            seg_we_m;
    logic [SW-1:0]   seg_ws_m;
    logic [LW-1:0]   seg_wl_m;
    logic [FI_W-1:0] seg_wi_m;

    logic cfg_wr, restart;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr == 2'd0);
    assign restart = !i_rst_n || cfg_wr;
    assign prdata  = (paddr == 2'd0) ? {15'd0, r_arena} : 32'd0;

    ffa_seg_table #(.FREE_ENTRIES(FREE_ENTRIES)) u_seg (
        .i_clk(i_clk), .i_rd_idx(seg_ri), .o_rd_start(seg_rs), .o_rd_len(seg_rl),
        .i_we(seg_we_m), .i_wr_idx(seg_wi_m), .i_wr_start(seg_ws_m),
        .i_wr_len(seg_wl_m)
    );

    ffa_live_table #(.LIVE_ENTRIES(LIVE_ENTRIES)) u_live (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(cfg_wr), .i_rd_idx(live_ri),
        .o_rd_valid(live_rv), .o_rd_ofs(live_ro), .o_rd_len(live_rlen),
        .o_rd_adj(live_radj), .i_set(live_set), .i_drop(live_drop),
        .i_wr_idx(live_wi), .i_wr_ofs(live_wo), .i_wr_len(live_wlen),
        .i_wr_adj(live_wadj)
    );

    // Alignment arithmetic on the segment just read.
    logic [3:0]  alog_c;
    logic [12:0] amask;
    logic [18:0] aligned_w;
    logic [18:0] total_w;
    logic [SW-1:0] bend;
    logic [SW-1:0] arena_sat;
    assign alog_c    = (r_alog > 4'(ffa_pkg::ALIGN_MAX)) ? 4'(ffa_pkg::ALIGN_MAX) : r_alog;
    assign amask     = 13'((17'd1 << alog_c) - 17'd1);
    assign aligned_w = (19'(seg_rs) + 19'(HEADER_BYTES) + 19'(amask)) & ~19'(amask);
    assign total_w   = 19'(r_size) + (aligned_w - 19'(seg_rs));
    assign bend      = r_bstart + SW'(r_blen);
    assign arena_sat = (pwdata[16:0] > 17'(ffa_pkg::ARENA_MAX_BYTES))
                       ? 17'(ffa_pkg::ARENA_MAX_BYTES) : pwdata[16:0];

    // Controller.
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_i = r_i; n_l = r_l; n_slot = r_slot;
        n_bstart = r_bstart; n_blen = r_blen; n_adj = r_adj; n_pend = r_pend;
        n_hasp = r_hasp; n_plen = r_plen; n_aligned = r_aligned; n_k = r_k;
        n_up = r_up; n_kind = r_kind; n_done = 1'b0; n_gofs = r_gofs;
        n_fb = r_fb; n_st = r_st;
        seg_ri = FI_W'(r_i); seg_we = 1'b0; seg_wi = FI_W'(r_i);
        seg_ws = r_bstart; seg_wl = r_blen;
        live_ri = LI_W'(r_l); live_set = 1'b0; live_drop = 1'b0;
        live_wi = r_slot; live_wo = r_aligned[15:0]; live_wlen = r_blen;
        live_wadj = r_adj;
        case (r_state)
            S_IDLE: begin
                if (i_start && !r_init) begin
                    n_i = '0; n_l = '0; n_hasp = 1'b0; n_gofs = '0; n_fb = '0;
                    n_st = ffa_pkg::ST_OK;
                    if (i_mode == ffa_pkg::MODE_ALLOC) begin
                        n_state = S_SRD;
                    end else begin
                        n_state = S_LRD; n_kind = K_FREE;
                    end
                end
            end
            S_SRD: begin
                // Read of entry r_i issued; end of list ends the scan.
                if (r_i >= r_cnt) begin
                    if (r_mode == ffa_pkg::MODE_ALLOC) begin
                        n_st = ffa_pkg::ST_NOFIT; n_state = S_DONE;
                    end else begin
                        n_state = S_NCHK;
                    end
                end else begin
                    n_state = (r_mode == ffa_pkg::MODE_ALLOC) ? S_SCHK : S_FCHK;
                end
            end
            S_SCHK: begin
                if (19'(seg_rl) < total_w) begin
                    n_i = r_i + 1'b1; n_state = S_SRD;
                end else begin
                    n_aligned = SW'(aligned_w);
                    n_adj = AW'(aligned_w - 19'(seg_rs));
                    n_bstart = seg_rs; n_plen = seg_rl;
                    n_blen = LW'(total_w);
                    n_l = '0; n_kind = K_ALLOC; n_state = S_LRD;
                end
            end
            S_LRD: begin
                if (r_l >= LC_W'(LIVE_ENTRIES)) begin
                    n_st = (r_kind == K_ALLOC) ? ffa_pkg::ST_FULL : ffa_pkg::ST_UNKNOWN;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (r_kind == K_ALLOC) begin
                    if (!live_rv) begin
                        n_slot = LI_W'(r_l);
                        // Commit the grant and fix the segment.
                        if (LW'(r_plen - r_blen) <= LW'(HEADER_BYTES)) begin
                            n_blen = r_plen;
                            n_up = 1'b0; n_k = r_i; n_state = S_SHRD;
                        end else begin
                            seg_we = 1'b1;
                            seg_ws = r_bstart + SW'(r_blen);
                            seg_wl = r_plen - r_blen;
                            n_state = S_DONE;
                        end
                        n_gofs = r_aligned[15:0];
                        live_set = 1'b1; live_wi = LI_W'(r_l);
                        live_wlen = (LW'(r_plen - r_blen) <= LW'(HEADER_BYTES))
                                    ? r_plen : r_blen;
                    end else begin
                        n_l = r_l + 1'b1; n_state = S_LRD;
                    end
                end else begin
                    if (live_rv && live_ro == r_rel) begin
                        n_slot = LI_W'(r_l); n_blen = live_rlen; n_adj = live_radj;
                        n_bstart = SW'(live_ro) - SW'(live_radj);
                        n_i = '0; n_state = S_SRD;
                    end else begin
                        n_l = r_l + 1'b1; n_state = S_LRD;
                    end
                end
            end
            S_FCHK: begin
                if (seg_rs >= bend) begin
                    n_state = S_NCHK;
                end else begin
                    n_hasp = 1'b1; n_pend = seg_rs + SW'(seg_rl); n_plen = seg_rl;
                    n_i = r_i + 1'b1; n_state = S_SRD;
                end
            end
            S_NCHK: begin
                // r_i is the first segment at or after the block end; its data
                // is on the read port when r_i < r_cnt.
                if (r_hasp && r_pend == r_bstart) begin
                    if (r_i < r_cnt && seg_rs == bend) begin
                        seg_we = 1'b1; seg_wi = FI_W'(r_i - 1'b1);
                        seg_ws = r_pend - SW'(r_plen);
                        seg_wl = r_plen + r_blen + seg_rl;
                        n_up = 1'b0; n_k = r_i; n_state = S_SHRD;
                    end else begin
                        seg_we = 1'b1; seg_wi = FI_W'(r_i - 1'b1);
                        seg_ws = r_pend - SW'(r_plen); seg_wl = r_plen + r_blen;
                        n_state = S_DONE;
                    end
                    live_drop = 1'b1;
                    n_fb = LW'(r_blen - LW'(r_adj));
                end else if (r_i < r_cnt && seg_rs == bend) begin
                    seg_we = 1'b1; seg_ws = r_bstart; seg_wl = r_blen + seg_rl;
                    live_drop = 1'b1; n_fb = LW'(r_blen - LW'(r_adj));
                    n_state = S_DONE;
                end else if (r_cnt >= FC_W'(FREE_ENTRIES)) begin
                    n_st = ffa_pkg::ST_FULL; n_state = S_DONE;
                end else begin
                    live_drop = 1'b1; n_fb = LW'(r_blen - LW'(r_adj));
                    n_up = 1'b1; n_k = r_cnt; n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                // Up: entry k takes k-1 down to i. Down: entry k takes k+1.
                if (r_up) begin
                    if (r_k == r_i) begin
                        seg_we = 1'b1; seg_wi = FI_W'(r_i);
                        n_cnt = r_cnt + 1'b1; n_state = S_DONE;
                    end else begin
                        seg_ri = FI_W'(r_k - 1'b1); n_state = S_SHWR;
                    end
                end else begin
                    if (r_k + 1'b1 >= r_cnt) begin
                        n_cnt = r_cnt - 1'b1; n_state = S_DONE;
                    end else begin
                        seg_ri = FI_W'(r_k + 1'b1); n_state = S_SHWR;
                    end
                end
            end
            S_SHWR: begin
                seg_we = 1'b1; seg_wi = FI_W'(r_k); seg_ws = seg_rs; seg_wl = seg_rl;
                n_k = r_up ? r_k - 1'b1 : r_k + 1'b1;
                n_state = S_SHRD;
            end
            S_DONE: begin
                n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (restart) begin
            r_state <= S_IDLE;
            r_cnt   <= FC_W'(1);
            r_done  <= 1'b0;
            r_arena <= !i_rst_n ? 17'(ffa_pkg::ARENA_MAX_BYTES) : arena_sat;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        if (i_start && r_state == S_IDLE && !r_init) begin
            r_mode <= i_mode; r_size <= i_req_size; r_alog <= i_align_log2;
            r_rel  <= i_release_offset;
        end
        r_i <= n_i; r_l <= n_l; r_slot <= n_slot; r_bstart <= n_bstart;
        r_blen <= n_blen; r_adj <= n_adj; r_pend <= n_pend; r_hasp <= n_hasp;
        r_plen <= n_plen; r_aligned <= n_aligned; r_k <= n_k; r_up <= n_up;
        r_kind <= n_kind; r_gofs <= n_gofs; r_fb <= n_fb; r_st <= n_st;
    end

    // Segment zero is rewritten by the restart through a second path.
    always_ff @(posedge i_clk) begin
        r_init <= restart;
    end
    assign seg_we_m = r_init | seg_we;
    assign seg_ws_m = r_init ? '0 : seg_ws;
    assign seg_wl_m = r_init ? r_arena : seg_wl;
    assign seg_wi_m = r_init ? '0 : seg_wi;

    assign o_busy           = (r_state != S_IDLE) || r_init;
    assign o_done           = r_done;
    assign o_granted_offset = r_gofs;
    assign o_freed_bytes    = r_fb;
    assign o_status         = r_st;
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator testbench
// Drives allocate and free commands into the allocator, predicts every result
// with a behavioral copy of the segment and live tables, and checks each
// result field by field. The arena size register is rewritten between
// phases, including the empty arena, oversized values and small arenas.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TOTAL_RANDOM = 1400;
    localparam int CYCLE_LIMIT  = 3000000;

    localparam int FREE_ENTRIES    = ffa_pkg::FREE_ENTRIES;
    localparam int LIVE_ENTRIES    = ffa_pkg::LIVE_ENTRIES;
    localparam int HEADER_BYTES    = ffa_pkg::HEADER_BYTES;
    localparam int ARENA_MAX_BYTES = ffa_pkg::ARENA_MAX_BYTES;
    localparam int ALIGN_MAX       = ffa_pkg::ALIGN_MAX;

    typedef struct {
        logic        mode;
        logic [16:0] size;
        logic [3:0]  align;
        logic [15:0] ofs;
        bit          pick_live;
    } t_cmd;

    typedef struct {
        logic [15:0] granted;
        logic [16:0] freed;
        logic [1:0]  status;
        int unsigned stamp;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_start;
    logic        o_busy;
    logic        i_mode;
    logic [16:0] i_req_size;
    logic [3:0]  i_align_log2;
    logic [15:0] i_release_offset;
    logic        o_done;
    logic [15:0] o_granted_offset;
    logic [16:0] o_freed_bytes;
    logic [1:0]  o_status;

    first_fit_free_list_allocator_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Pending commands, expected outcomes and run bookkeeping.
    t_cmd        cmd_q[$];
    t_outcome    outcome_q[$];
    int unsigned cyc = 0;
    int          errors = 0;
    int          accepted = 0;
    int          checked = 0;
    int          n_status[4] = '{0, 0, 0, 0};

    // Shadow copy of the allocator state.
    int unsigned arena_size;
    int unsigned seg_base[FREE_ENTRIES + 1];
    int unsigned seg_len[FREE_ENTRIES + 1];
    int unsigned seg_num;
    int unsigned live_ofs[LIVE_ENTRIES];
    int unsigned live_len[LIVE_ENTRIES];
    int unsigned live_adj[LIVE_ENTRIES];
    bit          live_on[LIVE_ENTRIES];

    function automatic void arena_restart();
        for (int k = 0; k <= FREE_ENTRIES; k++) begin
            seg_base[k] = 0;
            seg_len[k] = 0;
        end
        for (int k = 0; k < LIVE_ENTRIES; k++) begin
            live_ofs[k] = 0;
            live_len[k] = 0;
            live_adj[k] = 0;
            live_on[k] = 1'b0;
        end
        seg_len[0] = arena_size;
        seg_num = 1;
    endfunction

    function automatic void seg_drop(int unsigned idx);
        for (int unsigned k = idx; k + 1 < seg_num; k++) begin
            seg_base[k] = seg_base[k + 1];
            seg_len[k] = seg_len[k + 1];
        end
        seg_num--;
    endfunction

    // First-fit allocation: scan segments, split or take whole, record grant.
    function automatic t_outcome grant_block(int unsigned size, int unsigned alog2);
        t_outcome    r;
        int unsigned al, base, len, aligned, adj, total, slot;
        r = '{granted: '0, freed: '0, status: ffa_pkg::ST_NOFIT, stamp: 0};
        if (alog2 > ALIGN_MAX) alog2 = ALIGN_MAX;
        al = 1 << alog2;
        for (int unsigned i = 0; i < seg_num && i < FREE_ENTRIES; i++) begin
            base = seg_base[i];
            len = seg_len[i];
            aligned = (base + HEADER_BYTES + al - 1) & ~(al - 1);
            adj = aligned - base;
            total = size + adj;
            if (len >= total) begin
                slot = LIVE_ENTRIES;
                for (int unsigned s = 0; s < LIVE_ENTRIES; s++) begin
                    if (!live_on[s] && slot == LIVE_ENTRIES) slot = s;
                end
                if (slot == LIVE_ENTRIES) begin
                    r.status = ffa_pkg::ST_FULL;
                    return r;
                end
                if (len - total <= HEADER_BYTES) begin
                    total = len;
                    seg_drop(i);
                end else begin
                    seg_base[i] = base + total;
                    seg_len[i] = len - total;
                end
                live_on[slot] = 1'b1;
                live_ofs[slot] = aligned & 32'hFFFF;
                live_len[slot] = total;
                live_adj[slot] = adj;
                r.granted = aligned[15:0];
                r.status = ffa_pkg::ST_OK;
                return r;
            end
        end
        return r;
    endfunction

    // Release: find the grant, reinsert its block and merge with neighbors.
    function automatic t_outcome release_block(int unsigned ofs);
        t_outcome    r;
        int unsigned slot, i, bstart, blen, bend, at, flen;
        bit          prev_join;
        r = '{granted: '0, freed: '0, status: ffa_pkg::ST_OK, stamp: 0};
        prev_join = 1'b0;
        slot = LIVE_ENTRIES;
        for (int unsigned s = 0; s < LIVE_ENTRIES; s++) begin
            if (slot == LIVE_ENTRIES && live_on[s] && live_ofs[s] == ofs) slot = s;
        end
        if (slot == LIVE_ENTRIES) begin
            r.status = ffa_pkg::ST_UNKNOWN;
            return r;
        end
        blen = live_len[slot];
        bstart = live_ofs[slot] - live_adj[slot];
        bend = bstart + blen;
        i = 0;
        while (i < seg_num && i < FREE_ENTRIES && seg_base[i] < bend) i++;
        if (i > 0 && seg_base[i - 1] + seg_len[i - 1] == bstart) prev_join = 1'b1;
        if (prev_join) begin
            at = i - 1;
            seg_len[at] += blen;
        end else if (i < seg_num && seg_base[i] == bend) begin
            at = i;
            seg_base[at] = bstart;
            seg_len[at] += blen;
            i = seg_num;
        end else begin
            if (seg_num >= FREE_ENTRIES) begin
                r.status = ffa_pkg::ST_FULL;
                return r;
            end
            for (int unsigned k = seg_num; k > i; k--) begin
                seg_base[k] = seg_base[k - 1];
                seg_len[k] = seg_len[k - 1];
            end
            seg_base[i] = bstart;
            seg_len[i] = blen;
            seg_num++;
            at = i;
            i = seg_num;
        end
        if (prev_join && i < seg_num && seg_base[i] == bend) begin
            seg_len[at] += seg_len[i];
            seg_drop(i);
        end
        live_on[slot] = 1'b0;
        flen = blen - live_adj[slot];
        r.freed = flen[16:0];
        return r;
    endfunction

    // Offset of a random live grant, or a random offset when none is live.
    function automatic logic [15:0] live_offset_pick();
        int unsigned n, k;
        n = 0;
        for (int s = 0; s < LIVE_ENTRIES; s++) if (live_on[s]) n++;
        if (n == 0) return 16'($urandom_range(0, 65535));
        k = $urandom_range(0, n - 1);
        for (int s = 0; s < LIVE_ENTRIES; s++) begin
            if (live_on[s]) begin
                if (k == 0) return live_ofs[s][15:0];
                k--;
            end
        end
        return 16'h0;
    endfunction

    // Sender idle rate by progress: 32 percent, then 85 percent, then none.
    function automatic bit sender_idles();
        if (accepted < TOTAL_RANDOM / 3) return $urandom_range(0, 99) < 32;
        if (accepted < 2 * TOTAL_RANDOM / 3) return $urandom_range(0, 99) < 85;
        return 1'b0;
    endfunction

    // Command driver: predicts each accepted item, then loads the next one.
    always @(posedge i_clk) begin
        t_cmd     nxt;
        t_outcome o;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                if (i_mode == ffa_pkg::MODE_ALLOC) o = grant_block(i_req_size, i_align_log2);
                else o = release_block(i_release_offset);
                o.stamp = cyc;
                outcome_q.push_back(o);
                accepted++;
            end
            if (!(i_start && o_busy)) begin
                if (cmd_q.size() > 0 && !sender_idles()) begin
                    nxt = cmd_q.pop_front();
                    if (nxt.pick_live) nxt.ofs = live_offset_pick();
                    i_mode <= nxt.mode;
                    i_req_size <= nxt.size;
                    i_align_log2 <= nxt.align;
                    i_release_offset <= nxt.ofs;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome e;
        cyc <= cyc + 1;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0 || outcome_q[0].stamp == cyc) begin
                $display("%0t: result with nothing expected: ofs %0d freed %0d status %0d",
                         $time, o_granted_offset, o_freed_bytes, o_status);
                errors++;
            end else begin
                e = outcome_q.pop_front();
                checked++;
                n_status[o_status]++;
                if (o_granted_offset !== e.granted) begin
                    $display("%0t: granted_offset expected %0d actual %0d",
                             $time, e.granted, o_granted_offset);
                    errors++;
                end
                if (o_freed_bytes !== e.freed) begin
                    $display("%0t: freed_bytes expected %0d actual %0d",
                             $time, e.freed, o_freed_bytes);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, e.status, o_status);
                    errors++;
                end
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_alloc(int unsigned size, int unsigned alog2);
        cmd_q.push_back('{mode: ffa_pkg::MODE_ALLOC, size: size[16:0], align: alog2[3:0],
                          ofs: 16'($urandom), pick_live: 1'b0});
    endtask

    task automatic push_free(int unsigned ofs, bit pick);
        cmd_q.push_back('{mode: ffa_pkg::MODE_FREE, size: 17'($urandom),
                          align: 4'($urandom), ofs: ofs[15:0], pick_live: pick});
    endtask

    // Waits until every command is issued and every result has arrived.
    task automatic drain();
        while (cmd_q.size() > 0 || outcome_q.size() > 0 || i_start || o_busy)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // APB write of the arena size: setup cycle, then access cycle.
    task automatic arena_write(logic [31:0] value);
        int unsigned v;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        v = value & 32'h1FFFF;
        arena_size = (v > ARENA_MAX_BYTES) ? ARENA_MAX_BYTES : v;
        arena_restart();
    endtask

    task automatic random_items(int n);
        for (int k = 0; k < n; k++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                r = $urandom_range(0, 99);
                if (r < 70) push_alloc($urandom_range(0, 400), $urandom_range(0, 15));
                else if (r < 90) push_alloc($urandom_range(0, 4000), $urandom_range(0, 15));
                else push_alloc($urandom_range(0, 131071) % 65537, $urandom_range(0, 15));
            end else if (r < 92) begin
                push_free(0, 1'b1);
            end else begin
                push_free($urandom_range(0, 65535), 1'b0);
            end
        end
    endtask

    // Stimulus sequence, phase by phase.
    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 2'd0;
        pwdata <= 32'h0;
        i_start <= 1'b0;
        i_mode <= ffa_pkg::MODE_ALLOC;
        i_req_size <= '0;
        i_align_log2 <= '0;
        i_release_offset <= '0;
        arena_size = ARENA_MAX_BYTES;
        arena_restart();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, alignments past the limit, unknown offsets.
        arena_write(32'd65536);
        push_alloc(0, 0);
        push_alloc(65536, 0);
        push_alloc(100, 15);
        push_alloc(1000, 12);
        push_alloc(17, 13);
        push_free(16'hFFFF, 1'b0);
        push_free(0, 1'b1);
        push_free(0, 1'b1);
        push_alloc(5000, 7);
        push_free(0, 1'b1);
        push_free(0, 1'b1);
        push_free(0, 1'b1);
        drain();

        // Empty arena: nothing fits.
        arena_write(32'd0);
        push_alloc(0, 0);
        push_alloc(1, 3);
        push_free(16, 1'b0);
        drain();

        // Zero-size grant landing at the arena end wraps to offset zero.
        arena_write(32'hFFFE_0000 | 32'd65536);
        push_alloc(65503, 0);
        push_alloc(0, 1);
        push_free(0, 1'b0);
        push_free(16, 1'b0);
        drain();

        // Live table full on allocate.
        arena_write(32'd65536);
        for (int k = 0; k < LIVE_ENTRIES + 1; k++) push_alloc(0, 0);
        push_free(16, 1'b0);
        push_alloc(3, 0);
        drain();

        // Free table full: growing sizes leave holes that never refit, and
        // the arena is sized so that the last grant takes the whole tail.
        arena_write(32'd10160);
        for (int k = 0; k < 124; k += 2) begin
            push_alloc(k + 1, 0);
            push_alloc(k + 2, 0);
            push_free(16 + k * (k + 1) / 2 + 16 * k, 1'b0);
        end
        push_alloc(125, 0);
        push_alloc(126, 0);
        push_free(16 + 124 * 125 / 2 + 16 * 124, 1'b0);
        push_alloc(127, 0);
        push_free(16 + 126 * 127 / 2 + 16 * 126, 1'b0);
        push_alloc(0, 0);
        drain();

        // Random phases over several arena sizes, the oversized value included.
        arena_write(32'd65536);
        random_items(400);
        drain();
        arena_write(32'd3000);
        random_items(360);
        drain();
        arena_write(32'h0001_FFFF);
        random_items(360);
        drain();
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results: %0d ok, %0d no fit, %0d table full, %0d unknown.",
                 checked, n_status[0], n_status[1], n_status[2], n_status[3]);
        $display("Arena sizes covered: empty, small, exact-fit and full, with wrap at end.");
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ffa_pkg.sv
design/ffa_live_table.sv
design/ffa_seg_table.sv
design/first_fit_free_list_allocator_unit.sv
tb/tb_top.sv
